// File: hw/rtl/acg_pkg.sv
package acg_pkg;

  localparam int DIV_STAGES  = 16;
  localparam int ROOT_STAGES = 8;
  localparam int DEPTH       = DIV_STAGES + ROOT_STAGES;

  // divider stage: partial remainder, divisor, quotient bits so far
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] w;
    logic [15:0] quo;
    logic        sat;
  } div_t;

  // square-root stage: radicand bits still to consume, root, remainder
  typedef struct packed {
    logic [15:0] q;
    logic [7:0]  root;
    logic [9:0]  rem;
    logic        sat;
  } root_t;

  // one restoring quotient bit; rem < w holds before and after for nonzero w
  function automatic div_t div_step(input div_t s);
    div_t        r;
    logic [32:0] t;
    r = s;
    t = {s.rem, 1'b0};
    if (t >= {1'b0, s.w}) begin
      t     = t - {1'b0, s.w};
      r.quo = {s.quo[14:0], 1'b1};
    end else begin
      r.quo = {s.quo[14:0], 1'b0};
    end
    r.rem = t[31:0];
    return r;
  endfunction

  // one root bit from two radicand bits
  function automatic root_t root_step(input root_t s);
    root_t       r;
    logic [11:0] cur;
    logic [11:0] t;
    r   = s;
    cur = {s.rem, s.q[15:14]};
    t   = {2'b00, s.root, 2'b01};
    if (cur >= t) begin
      cur    = cur - t;
      r.root = {s.root[6:0], 1'b1};
    end else begin
      r.root = {s.root[6:0], 1'b0};
    end
    r.rem = cur[9:0];
    r.q   = {s.q[13:0], 2'b00};
    return r;
  endfunction

endpackage

// File: hw/rtl/acg_lane.sv
module acg_lane (
  input  logic                   clk,
  input  logic [acg_pkg::DEPTH:1] en,
  input  logic [31:0]            sum,
  input  logic [31:0]            weight,
  output logic [7:0]             pix
);

  acg_pkg::div_t  div_q  [1:acg_pkg::DIV_STAGES];
  acg_pkg::root_t root_q [1:acg_pkg::ROOT_STAGES];
  acg_pkg::div_t  init;
  acg_pkg::root_t root_in;
  logic           positive;
  logic           sat;

  // c <= 0 gives 0; c >= w means quotient over 65535, root saturates to 255
  always_comb begin
    positive   = !sum[31] && (sum != 32'd0);
    sat        = positive && (sum >= weight);
    init.rem   = (positive && !sat) ? sum : 32'd0;
    init.w     = weight;
    init.quo   = 16'd0;
    init.sat   = sat;
    root_in.q    = div_q[acg_pkg::DIV_STAGES].quo;
    root_in.root = 8'd0;
    root_in.rem  = 10'd0;
    root_in.sat  = div_q[acg_pkg::DIV_STAGES].sat;
  end

  for (genvar k = 1; k <= acg_pkg::DIV_STAGES; k++) begin : g_div
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en[k]) div_q[k] <= acg_pkg::div_step(init);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[k]) div_q[k] <= acg_pkg::div_step(div_q[k-1]);
      end
    end
  end

  for (genvar k = 1; k <= acg_pkg::ROOT_STAGES; k++) begin : g_root
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en[acg_pkg::DIV_STAGES + k]) root_q[k] <= acg_pkg::root_step(root_in);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[acg_pkg::DIV_STAGES + k]) root_q[k] <= acg_pkg::root_step(root_q[k-1]);
      end
    end
  end

  assign pix = root_q[acg_pkg::ROOT_STAGES].sat ? 8'hFF
                                                : root_q[acg_pkg::ROOT_STAGES].root;

endmodule

// File: hw/rtl/accumulated_color_to_rgb8_gamma2.sv
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+-------------------------------------------
// input    | in  | in_valid / in_stall  | red_sum, green_sum, blue_sum, weight_sum
// output   | out | out_valid / out_stall| red_out, green_out, blue_out, weight_error
//
// One item per cycle sustained while out_stall is low; 16 divider stages, one quotient
// bit each, then 8 square-root stages, one root bit each, per channel lane.
// Each stage advances on its own when empty or when the next one moves, so bubbles
// collapse and input is taken while a finished result waits if any stage is empty.
// rst clears the valid bits only.
module accumulated_color_to_rgb8_gamma2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] red_sum,
  input  logic [31:0] green_sum,
  input  logic [31:0] blue_sum,
  input  logic [31:0] weight_sum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        weight_error
);

  logic [acg_pkg::DEPTH:1] vld;
  logic [acg_pkg::DEPTH:1] err;
  logic [acg_pkg::DEPTH:1] en;
  logic [7:0]              red_pix;
  logic [7:0]              green_pix;
  logic [7:0]              blue_pix;

  always_comb begin
    en[acg_pkg::DEPTH] = !vld[acg_pkg::DEPTH] || !out_stall;
    for (int k = acg_pkg::DEPTH - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int k = 2; k <= acg_pkg::DEPTH; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) err[1] <= (weight_sum == 32'd0);
    for (int k = 2; k <= acg_pkg::DEPTH; k++) begin
      if (en[k]) err[k] <= err[k-1];
    end
  end

  acg_lane u_red (
    .clk(clk), .en(en), .sum(red_sum), .weight(weight_sum), .pix(red_pix)
  );
  acg_lane u_green (
    .clk(clk), .en(en), .sum(green_sum), .weight(weight_sum), .pix(green_pix)
  );
  acg_lane u_blue (
    .clk(clk), .en(en), .sum(blue_sum), .weight(weight_sum), .pix(blue_pix)
  );

  assign in_stall     = !en[1];
  assign out_valid    = vld[acg_pkg::DEPTH];
  assign weight_error = err[acg_pkg::DEPTH];
  // zero weight forces all channels dark
  assign red_out      = weight_error ? 8'd0 : red_pix;
  assign green_out    = weight_error ? 8'd0 : green_pix;
  assign blue_out     = weight_error ? 8'd0 : blue_pix;

endmodule

// File: sim/accumulated_color_to_rgb8_gamma2_tb.sv
module accumulated_color_to_rgb8_gamma2_tb;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       werr;
  } pixel_t;

  // expected-pixel queue plus the gamma-2 predictor
  class pixel_scoreboard;
    pixel_t pending[$];
    int     errors;

    function logic [7:0] isqrt16(logic [31:0] v);
      logic [31:0] r;
      r = 0;
      for (int b = 7; b >= 0; b--) begin
        if ((r | (32'd1 << b)) * (r | (32'd1 << b)) <= v) r = r | (32'd1 << b);
      end
      return r[7:0];
    endfunction

    function logic [7:0] gamma_chan(logic [31:0] c, logic [31:0] w);
      logic [63:0] q;
      if (c == 0 || c[31]) return 8'd0;
      q = {16'd0, c, 16'd0} / {32'd0, w};
      if (q > 64'd65535) q = 64'd65535;
      return isqrt16(q[31:0]);
    endfunction

    function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                             logic [31:0] w);
      pixel_t p;
      if (w == 0) begin
        p.red = 0; p.green = 0; p.blue = 0; p.werr = 1'b1;
      end else begin
        p.red = gamma_chan(r, w);
        p.green = gamma_chan(g, w);
        p.blue = gamma_chan(b, w);
        p.werr = 1'b0;
      end
      pending.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d err=%0b", $time,
                 got.red, got.green, got.blue, got.werr);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.red !== e.red) begin
        $display("%0t: red exp %0d got %0d", $time, e.red, got.red); errors++;
      end
      if (got.green !== e.green) begin
        $display("%0t: green exp %0d got %0d", $time, e.green, got.green); errors++;
      end
      if (got.blue !== e.blue) begin
        $display("%0t: blue exp %0d got %0d", $time, e.blue, got.blue); errors++;
      end
      if (got.werr !== e.werr) begin
        $display("%0t: weight_error exp %0b got %0b", $time, e.werr, got.werr);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] red_sum = 0, green_sum = 0, blue_sum = 0, weight_sum = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [7:0]  red_out, green_out, blue_out;
  logic        weight_error;

  pixel_scoreboard sb = new();
  bit          sending_done = 0;
  bit          hold_off = 0;
  int          idle_cycles = 0;
  int          n_random = 1480;

  accumulated_color_to_rgb8_gamma2 uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // called at a falling edge; valid stays up into the next call when no gap is drawn
  task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                            logic [31:0] w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; red_sum <= r; green_sum <= g; blue_sum <= b; weight_sum <= w;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(r, g, b, w);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return -$urandom_range(0, 65536);
      2: return $urandom_range(0, 32'h0001_0000);
      3: return $urandom_range(0, 32'h7fff_ffff);
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom();
      2: return $urandom_range(1, 16);
      default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
    endcase
  endfunction

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_pixel(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1);
    send_pixel(32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'hffff_ffff);
    send_pixel(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_pixel(32'h0000_fe02, 32'h0000_fe01, 32'h0000_fe00, 32'h0001_0000);
    send_pixel(32'h1234_5678, 32'h1, 32'hffff_fffe, 32'h0);
    send_pixel(32'h0, 32'h0, 32'h0, 32'h0);
    send_pixel(32'h1, 32'h2, 32'h3, 32'h8000_0000);
    send_pixel(32'h4000_0000, 32'h0000_4000, 32'h0000_0100, 32'h0001_0000);
    send_pixel(32'h5555_5555, 32'h2aaa_aaaa, 32'h0000_ffff, 32'h0002_0000);
    send_pixel(32'h0000_0001, 32'h0000_0004, 32'h0000_0009, 32'h0001_0000);
    hold_off <= 1;
    for (int i = 0; i < 60; i++) send_pixel(rand_chan(), rand_chan(), rand_chan(),
                                            rand_weight());
    for (int i = 0; i < n_random; i++)
      send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_weight());
    in_valid <= 0;
    sending_done = 1;
  end

  // receiver; free-running through the directed part, then one long hold-off, then random stalls
  initial begin
    int gap;
    @(negedge clk);
    out_stall <= 0;
    wait (hold_off);
    @(negedge clk);
    out_stall <= 1;
    repeat (80) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_stall <= 1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    if (!rst && out_valid && !out_stall) begin
      got.red = red_out; got.green = green_out; got.blue = blue_out;
      got.werr = weight_error;
      sb.check_pixel(got);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (!(sending_done && sb.pending.size() == 0)) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("accumulated_color_to_rgb8_gamma2_tb: PASS");
    else $display("accumulated_color_to_rgb8_gamma2_tb: FAIL");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 2000);
    $display("%0t: timeout", $time);
    $display("accumulated_color_to_rgb8_gamma2_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/acg_pkg.sv
hw/rtl/acg_lane.sv
hw/rtl/accumulated_color_to_rgb8_gamma2.sv
sim/accumulated_color_to_rgb8_gamma2_tb.sv
